// ===== hw/rtl/goh_pkg.sv =====
// ----------------------------------------------------------------------------
// goh_pkg
// Shared field widths and the vote word passed from the binning pipeline to
// the accumulate stage of the orientation histogram.
// ----------------------------------------------------------------------------
package goh_pkg;

  localparam int ANGLE_IN_W = 16;
  localparam int MAG_W      = 16;
  localparam int IDX_OUT_W  = 3;
  localparam int TOTAL_W    = 32;

  // addends per storage resource: even bank, odd bank, top bin register
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [MAG_W-1:0] ev_add;
    logic [MAG_W-1:0] od_add;
    logic [MAG_W-1:0] tl_add;
  } vote_t;

endpackage

// ===== hw/rtl/goh_bank.sv =====
// ----------------------------------------------------------------------------
// goh_bank
// One histogram bank: synchronous RAM with registered read, per-entry valid
// bits (unwritten entries read as zero) and a bypass for a write to the
// address read at the same edge.
// ----------------------------------------------------------------------------
module goh_bank #(
  parameter int DEPTH = 4,
  parameter int AW    = 2,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [DW-1:0] ram_q;
  logic [DW-1:0] byp_data_q;
  logic          byp_q;
  logic          hit_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    ram_q      <= mem[raddr_i];
    byp_data_q <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      byp_q     <= 1'b0;
      hit_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      byp_q     <= we_i && (waddr_i == raddr_i);
      hit_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = byp_q ? byp_data_q : (hit_vld_q ? ram_q : '0);

endmodule

// ===== hw/rtl/goh_vote.sv =====
// ----------------------------------------------------------------------------
// goh_vote
// Two-stage binning pipeline: finds main and neighbor bins and the main
// weight, maps them onto even bank, odd bank and top bin register, then splits
// the magnitude with one multiply (unweighted: all of it to the main bin).
// ----------------------------------------------------------------------------
module goh_vote
  import goh_pkg::*;
#(
  parameter int BINS       = 8,
  parameter int ANGLE_BITS = 16,
  parameter int BA_W       = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [ANGLE_IN_W-1:0] angle_i,
  input  logic [MAG_W-1:0]      magnitude_i,
  input  logic                  last_pixel_i,
  input  logic                  weighted_i,
  output logic [BA_W-1:0]       rd_ev_addr_o,
  output logic [BA_W-1:0]       rd_od_addr_o,
  output vote_t                 vote_o,
  output logic [BA_W-1:0]       wr_ev_addr_o,
  output logic [BA_W-1:0]       wr_od_addr_o
);

  localparam int IDX_W = $clog2(BINS);
  localparam int P_W   = ANGLE_BITS + IDX_W;
  localparam int W_W   = ANGLE_BITS + 1;
  localparam int PR_W  = MAG_W + W_W;
  localparam logic [W_W-1:0]        FULL     = {1'b1, {ANGLE_BITS{1'b0}}};
  localparam logic [ANGLE_BITS-1:0] HALF     = {1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam logic [IDX_W-1:0]      LAST_BIN = IDX_W'(BINS - 1);

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_MAIN,
    SRC_SIDE
  } src_e;

  function automatic logic [BA_W-1:0] bank_addr(input logic [IDX_W-1:0] b);
    return BA_W'(b >> 1);
  endfunction

  // stage 0: bin selection
  logic [ANGLE_BITS+ANGLE_IN_W-1:0] ang_ext;
  logic [ANGLE_BITS-1:0]            ang;
  logic [P_W-1:0]                   pos;
  logic [ANGLE_BITS-1:0]            rem;
  logic [IDX_W-1:0]                 hi, hi_nxt, main_bin, side_bin;
  logic                             up;
  logic [W_W-1:0]                   weight;
  logic                             main_tl, side_tl, main_ev, side_ev, main_od, side_od;
  src_e                             ev_sel, od_sel, tl_sel;
  logic [BA_W-1:0]                  ev_addr, od_addr;

  assign ang_ext = {{ANGLE_BITS{1'b0}}, angle_i};
  assign ang     = ang_ext[ANGLE_BITS-1:0];
  assign pos     = P_W'(ang) * P_W'(BINS);
  assign rem     = pos[ANGLE_BITS-1:0];
  assign hi      = pos[P_W-1:ANGLE_BITS];
  // exact half above zero stays in bin 0, other ties go up
  assign up       = (rem > HALF) || ((rem == HALF) && (hi != '0));
  assign hi_nxt   = (hi == LAST_BIN) ? '0 : hi + 1'b1;
  assign main_bin = up ? hi_nxt : hi;
  assign side_bin = up ? hi : hi_nxt;
  assign weight   = up ? {1'b0, rem} : FULL - {1'b0, rem};

  assign main_tl = (main_bin == LAST_BIN);
  assign side_tl = (side_bin == LAST_BIN);
  assign main_ev = !main_tl && !main_bin[0];
  assign side_ev = !side_tl && !side_bin[0];
  assign main_od = !main_tl && main_bin[0];
  assign side_od = !side_tl && side_bin[0];

  always_comb begin
    ev_sel  = SRC_NONE;
    od_sel  = SRC_NONE;
    tl_sel  = SRC_NONE;
    ev_addr = '0;
    od_addr = '0;
    if (main_ev) begin
      ev_sel  = SRC_MAIN;
      ev_addr = bank_addr(main_bin);
    end else if (side_ev) begin
      ev_sel  = SRC_SIDE;
      ev_addr = bank_addr(side_bin);
    end
    if (main_od) begin
      od_sel  = SRC_MAIN;
      od_addr = bank_addr(main_bin);
    end else if (side_od) begin
      od_sel  = SRC_SIDE;
      od_addr = bank_addr(side_bin);
    end
    if (main_tl) begin
      tl_sel = SRC_MAIN;
    end else if (side_tl) begin
      tl_sel = SRC_SIDE;
    end
  end

  // stage 1: split
  logic             s1_valid_q, s1_last_q;
  logic [BA_W-1:0]  s1_ev_addr_q, s1_od_addr_q;
  src_e             s1_ev_sel_q, s1_od_sel_q, s1_tl_sel_q;
  logic [MAG_W-1:0] s1_mag_q;
  logic [W_W-1:0]   s1_weight_q;
  logic [PR_W-1:0]  prod;
  logic [MAG_W-1:0] share, rest;
  vote_t            vote_d, vote_q;
  logic [BA_W-1:0]  s2_ev_addr_q, s2_od_addr_q;

  function automatic logic [MAG_W-1:0] pick(input src_e sel, input logic [MAG_W-1:0] a,
                                            input logic [MAG_W-1:0] b);
    logic [MAG_W-1:0] r;
    case (sel)
      SRC_MAIN: r = a;
      SRC_SIDE: r = b;
      default:  r = '0;
    endcase
    return r;
  endfunction

  assign prod = PR_W'(s1_mag_q) * PR_W'(s1_weight_q);
  assign share = weighted_i ? prod[ANGLE_BITS +: MAG_W] : s1_mag_q;
  assign rest  = s1_mag_q - share;

  always_comb begin
    vote_d.valid  = s1_valid_q;
    vote_d.last   = s1_last_q;
    vote_d.ev_add = pick(s1_ev_sel_q, share, rest);
    vote_d.od_add = pick(s1_od_sel_q, share, rest);
    vote_d.tl_add = pick(s1_tl_sel_q, share, rest);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      vote_q     <= '0;
    end else begin
      s1_valid_q <= accept_i;
      vote_q     <= vote_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q     <= last_pixel_i;
    s1_ev_addr_q  <= ev_addr;
    s1_od_addr_q  <= od_addr;
    s1_ev_sel_q   <= ev_sel;
    s1_od_sel_q   <= od_sel;
    s1_tl_sel_q   <= tl_sel;
    s1_mag_q      <= magnitude_i;
    s1_weight_q   <= weight;
    s2_ev_addr_q  <= s1_ev_addr_q;
    s2_od_addr_q  <= s1_od_addr_q;
  end

  assign rd_ev_addr_o = s1_ev_addr_q;
  assign rd_od_addr_o = s1_od_addr_q;
  assign vote_o       = vote_q;
  assign wr_ev_addr_o = s2_ev_addr_q;
  assign wr_od_addr_o = s2_od_addr_q;

endmodule

// ===== hw/rtl/gradient_orientation_histogram.sv =====
// ----------------------------------------------------------------------------
// gradient_orientation_histogram
// Orientation histogram with soft binning between the two nearest bins.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one pixel word per cycle when
// in_ready_o is high: angle, magnitude and a last-pixel flag. Output channel
// (out_valid_o/out_ready_i) returns one word per bin, bins 0 to BINS-1 in
// order, after each last pixel; last_bin_o marks the final bin word.
// Config channel (cfg_valid_i/cfg_ready_o) writes weighted_mode, always ready.
// Pixels run through a three-stage pipeline: bin selection, one multiply for
// the split, read-modify-write of two bins. Bins sit in an even bank and an
// odd bank, registered-read RAMs, plus a register for the top bin, so the two
// adjacent bins of a pixel never share a write port; a bypass in each bank
// covers back-to-back updates of one entry. Throughput is one pixel per cycle
// while in_ready_o is high. A last pixel closes the input: once it leaves the
// pipeline, each bin is read from its bank or top bin register, loaded into
// the output register and cleared, one bin at a time while out_ready_i is high.
// in_ready_o returns when the final bin word is loaded. A stalled receiver
// holds the output word and pauses the readout.
// Reset clears the histogram and sets weighted_mode to 1.
// ----------------------------------------------------------------------------
module gradient_orientation_histogram
  import goh_pkg::*;
#(
  parameter int BINS       = 8,
  parameter int ANGLE_BITS = 16,
  parameter int ACC_BITS   = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  weighted_mode_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ANGLE_IN_W-1:0] angle_i,
  input  logic [MAG_W-1:0]      magnitude_i,
  input  logic                  last_pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [IDX_OUT_W-1:0]  bin_index_o,
  output logic [TOTAL_W-1:0]    bin_total_o,
  output logic                  last_bin_o
);

  localparam int IDX_W      = $clog2(BINS);
  localparam int BANK_DEPTH = BINS / 2;
  localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(BINS - 1);

  function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
                                                  input logic [MAG_W-1:0] b);
    logic [ACC_BITS:0] s;
    s = {1'b0, a} + (ACC_BITS + 1)'(b);
    return s[ACC_BITS] ? '1 : s[ACC_BITS-1:0];
  endfunction

  logic in_acc;
  logic weighted_q;
  logic busy_q, dump_q, rd_pend_q;
  logic [IDX_W-1:0] k_q;
  logic [ACC_BITS-1:0] tail_q;

  vote_t vote;
  logic [BA_W-1:0] vt_rd_ev, vt_rd_od, vt_wr_ev, vt_wr_od;
  logic [BA_W-1:0] dump_addr;
  logic [BA_W-1:0] ev_raddr, od_raddr, ev_waddr, od_waddr;
  logic [ACC_BITS-1:0] ev_rdata, od_rdata, ev_wdata, od_wdata, dump_val;
  logic ev_we, od_we;
  logic k_tail, issue, dump_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !busy_q;
  assign in_acc      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weighted_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      weighted_q <= weighted_mode_i;
    end
  end

  goh_vote #(
    .BINS      (BINS),
    .ANGLE_BITS(ANGLE_BITS),
    .BA_W      (BA_W)
  ) u_vote (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .angle_i     (angle_i),
    .magnitude_i (magnitude_i),
    .last_pixel_i(last_pixel_i),
    .weighted_i  (weighted_q),
    .rd_ev_addr_o(vt_rd_ev),
    .rd_od_addr_o(vt_rd_od),
    .vote_o      (vote),
    .wr_ev_addr_o(vt_wr_ev),
    .wr_od_addr_o(vt_wr_od)
  );

  // readout sequencer
  assign k_tail    = (k_q == LAST_BIN);
  assign dump_addr = k_tail ? '0 : BA_W'(k_q >> 1);
  assign issue     = dump_q && !rd_pend_q && (!out_valid_o || out_ready_i);
  assign dump_load = dump_q && rd_pend_q;
  assign dump_val  = k_tail ? tail_q : (k_q[0] ? od_rdata : ev_rdata);

  assign ev_raddr = dump_q ? dump_addr : vt_rd_ev;
  assign od_raddr = dump_q ? dump_addr : vt_rd_od;
  assign ev_we    = dump_load ? (!k_tail && !k_q[0]) : vote.valid;
  assign od_we    = dump_load ? (!k_tail && k_q[0]) : vote.valid;
  assign ev_waddr = dump_load ? dump_addr : vt_wr_ev;
  assign od_waddr = dump_load ? dump_addr : vt_wr_od;
  assign ev_wdata = dump_load ? '0 : sat_add(ev_rdata, vote.ev_add);
  assign od_wdata = dump_load ? '0 : sat_add(od_rdata, vote.od_add);

  goh_bank #(
    .DEPTH(BANK_DEPTH),
    .AW   (BA_W),
    .DW   (ACC_BITS)
  ) u_bank_ev (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (ev_we),
    .waddr_i(ev_waddr),
    .wdata_i(ev_wdata),
    .raddr_i(ev_raddr),
    .rdata_o(ev_rdata)
  );

  goh_bank #(
    .DEPTH(BANK_DEPTH),
    .AW   (BA_W),
    .DW   (ACC_BITS)
  ) u_bank_od (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (od_we),
    .waddr_i(od_waddr),
    .wdata_i(od_wdata),
    .raddr_i(od_raddr),
    .rdata_o(od_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q    <= '0;
      busy_q    <= 1'b0;
      dump_q    <= 1'b0;
      rd_pend_q <= 1'b0;
      k_q       <= '0;
    end else begin
      if (in_acc && last_pixel_i) begin
        busy_q <= 1'b1;
      end
      if (vote.valid) begin
        tail_q <= sat_add(tail_q, vote.tl_add);
        if (vote.last) begin
          dump_q <= 1'b1;
          k_q    <= '0;
        end
      end
      rd_pend_q <= issue;
      if (dump_load) begin
        k_q <= k_q + 1'b1;
        if (k_tail) begin
          tail_q <= '0;
          dump_q <= 1'b0;
          busy_q <= 1'b0;
        end
      end
    end
  end

  // output register
  logic [IDX_W+IDX_OUT_W-1:0]  k_ext;
  logic [ACC_BITS+TOTAL_W-1:0] tot_ext;
  logic                        out_valid_q;
  logic [IDX_OUT_W-1:0]        bin_index_q;
  logic [TOTAL_W-1:0]          bin_total_q;
  logic                        last_bin_q;

  assign k_ext   = {{IDX_OUT_W{1'b0}}, k_q};
  assign tot_ext = {{TOTAL_W{1'b0}}, dump_val};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dump_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dump_load) begin
      bin_index_q <= k_ext[IDX_OUT_W-1:0];
      bin_total_q <= tot_ext[TOTAL_W-1:0];
      last_bin_q  <= k_tail;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_index_o = bin_index_q;
  assign bin_total_o = bin_total_q;
  assign last_bin_o  = last_bin_q;

endmodule

// ===== hw/rtl/goh_checker.sv =====
// ----------------------------------------------------------------------------
// goh_checker
// Port-level checks of the orientation histogram: output hold under stall,
// input closed during readout, final bin word numbering.
// ----------------------------------------------------------------------------
module goh_checker
  import goh_pkg::*;
#(
  parameter int BINS = 8
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  last_pixel_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [IDX_OUT_W-1:0]  bin_index_o,
  input logic [TOTAL_W-1:0]    bin_total_o,
  input logic                  last_bin_o
);

  localparam logic [IDX_OUT_W-1:0] LAST_IDX = IDX_OUT_W'(BINS - 1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bin_index_o) &&
      $stable(bin_total_o) && $stable(last_bin_o))
    else $error("output word changed while stalled");

  a_last_closes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_pixel_i |=> !in_ready_o)
    else $error("input open after last pixel");

  a_readout_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_bin_o |-> !in_ready_o)
    else $error("input open during readout");

  a_final_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_bin_o |-> bin_index_o == LAST_IDX)
    else $error("final bin word has wrong index");

endmodule

bind gradient_orientation_histogram goh_checker #(
  .BINS(BINS)
) u_goh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_pixel_i(last_pixel_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .bin_index_o (bin_index_o),
  .bin_total_o (bin_total_o),
  .last_bin_o  (last_bin_o)
);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gradient orientation histogram. Streams pixel
// words under random idling, predicts each bin word through an internal
// soft-binning histogram model, and compares every bin word field by field.
// Covers bin boundary ties, wrap-around at the circle and both vote modes.
// ----------------------------------------------------------------------------
module testbench
  import goh_pkg::*;
();

  localparam int NUM_BINS = 8;
  localparam longint unsigned TURN = 64'd1 << 16;
  localparam longint unsigned BIN_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [ANGLE_IN_W-1:0] angle;
    logic [MAG_W-1:0]      mag;
    logic                  last;
  } pixel_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] idx;
    logic [TOTAL_W-1:0]   total;
    logic                 last;
  } bin_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic                  weighted_mode_i = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [ANGLE_IN_W-1:0] angle_i = '0;
  logic [MAG_W-1:0]      magnitude_i = '0;
  logic                  last_pixel_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [IDX_OUT_W-1:0]  bin_index_o;
  logic [TOTAL_W-1:0]    bin_total_o;
  logic                  last_bin_o;

  pixel_t          pixel_backlog[$];
  bin_word_t       bin_words_due[$];
  longint unsigned hist_model[NUM_BINS];
  bit              mode_model = 1'b1;
  bit              quiet = 1'b0;
  int              send_gap = 0;
  int              recv_stall = 0;
  int              errors = 0;
  bin_word_t       due;

  gradient_orientation_histogram u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .weighted_mode_i (weighted_mode_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .angle_i         (angle_i),
    .magnitude_i     (magnitude_i),
    .last_pixel_i    (last_pixel_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bin_index_o     (bin_index_o),
    .bin_total_o     (bin_total_o),
    .last_bin_o      (last_bin_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic bump_bin(input int b, input longint unsigned v);
    if (v > BIN_MAX - hist_model[b]) begin
      hist_model[b] = BIN_MAX;
    end else begin
      hist_model[b] = hist_model[b] + v;
    end
  endtask

  task automatic cast_vote(input logic [ANGLE_IN_W-1:0] ang, input logic [MAG_W-1:0] mag,
                           input logic last);
    longint unsigned pos, twice, offset, center, share;
    int major, minor, i;
    bin_word_t w;
    pos = 64'(ang) * NUM_BINS;
    twice = pos * 2;
    if (twice <= TURN || twice >= (2 * NUM_BINS - 1) * TURN) begin
      major = 0;
      if (twice <= TURN) begin
        offset = pos;
        minor = 1;
      end else begin
        offset = NUM_BINS * TURN - pos;
        minor = NUM_BINS - 1;
      end
    end else begin
      major = int'((twice + TURN) / (2 * TURN));
      if (major >= NUM_BINS) major = NUM_BINS - 1;
      center = major * TURN;
      if (pos >= center) begin
        offset = pos - center;
        minor = (major + 1 == NUM_BINS) ? 0 : major + 1;
      end else begin
        offset = center - pos;
        minor = major - 1;
      end
    end
    if (offset > TURN) offset = TURN;
    if (mode_model) begin
      share = (64'(mag) * (TURN - offset)) >> 16;
      bump_bin(major, share);
      bump_bin(minor, 64'(mag) - share);
    end else begin
      bump_bin(major, 64'(mag));
    end
    if (last) begin
      for (i = 0; i < NUM_BINS; i++) begin
        w.idx = IDX_OUT_W'(i);
        w.total = hist_model[i][TOTAL_W-1:0];
        w.last = (i == NUM_BINS - 1);
        bin_words_due = {bin_words_due, w};
        hist_model[i] = 0;
      end
    end
  endtask

  // pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        cast_vote(angle_i, magnitude_i, last_pixel_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pixel_backlog.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 14);
          in_valid_i <= 1'b0;
        end else begin
          angle_i <= pixel_backlog[0].angle;
          magnitude_i <= pixel_backlog[0].mag;
          last_pixel_i <= pixel_backlog[0].last;
          in_valid_i <= 1'b1;
          void'(pixel_backlog.pop_front());
        end
      end
    end
  end

  // bin word monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (bin_words_due.size() == 0) begin
          $error("unexpected bin word: index %0d total %0d", bin_index_o, bin_total_o);
          errors++;
        end else begin
          due = bin_words_due.pop_front();
          if (bin_index_o !== due.idx) begin
            $error("bin_index expected %0d actual %0d", due.idx, bin_index_o);
            errors++;
          end
          if (bin_total_o !== due.total) begin
            $error("bin_total expected %0d actual %0d", due.total, bin_total_o);
            errors++;
          end
          if (last_bin_o !== due.last) begin
            $error("last_bin expected %0d actual %0d", due.last, last_bin_o);
            errors++;
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        recv_stall <= $urandom_range(0, 14);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic add_pixel(input logic [ANGLE_IN_W-1:0] a, input logic [MAG_W-1:0] m,
                           input logic l);
    pixel_t p;
    p.angle = a;
    p.mag = m;
    p.last = l;
    pixel_backlog = {pixel_backlog, p};
  endtask

  // wait for the pipeline to drain and all bin words to be taken
  task automatic settle();
    while (pixel_backlog.size() != 0 || in_valid_i || bin_words_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    weighted_mode_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_model = v;
  endtask

  task automatic add_directed();
    add_pixel(16'h0000, 16'hFFFF, 1'b0);
    add_pixel(16'h1000, 16'hFFFF, 1'b0); // half a bin above zero
    add_pixel(16'h1001, 16'h8000, 1'b0);
    add_pixel(16'hF000, 16'h1234, 1'b0); // half a bin below a full turn
    add_pixel(16'hEFFF, 16'hFFFF, 1'b0);
    add_pixel(16'hFFFF, 16'hFFFF, 1'b0);
    add_pixel(16'h3000, 16'h7FFF, 1'b0); // boundary tie goes up
    add_pixel(16'h2000, 16'hFFFF, 1'b0);
    add_pixel(16'h1FFF, 16'h0001, 1'b0);
    add_pixel(16'h2001, 16'hFFFF, 1'b0);
    add_pixel(16'hD000, 16'hAAAA, 1'b0);
    add_pixel(16'h5555, 16'h0000, 1'b0);
    add_pixel(16'hFFFF, 16'h0001, 1'b1);
  endtask

  task automatic add_random(input int count);
    int k, sel;
    logic [ANGLE_IN_W-1:0] a;
    logic [MAG_W-1:0] m;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        a = 16'($urandom_range(0, 16'hFFFF));
      end else if (sel < 9) begin
        // near a bin center or a bin boundary
        a = 16'($urandom_range(0, 15) * 16'h1000 + $urandom_range(0, 4) - 2);
      end else begin
        a = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) m = 16'h0000;
      else if (sel == 1) m = 16'hFFFF;
      else m = 16'($urandom_range(0, 16'hFFFF));
      add_pixel(a, m, $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin : main
    int ph;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // weighted mode straight out of reset
    @(negedge clk_i);
    add_directed();
    settle();
    write_mode(1'b0);
    @(negedge clk_i);
    add_directed();
    settle();

    for (ph = 0; ph < 6; ph++) begin
      write_mode((ph % 2 == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
      if (ph == 5) quiet = 1'b1;
      @(negedge clk_i);
      add_random(15);
      settle();
    end

    write_mode(1'b1);
    @(negedge clk_i);
    add_random(10);
    add_pixel(16'h7000, 16'hFFFF, 1'b1);
    settle();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
